// ===== hdl/assert_macros.svh =====
// assertion helpers, sampled on clk and disabled during arst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/amc_pkg.sv =====
package amc_pkg;

	localparam int COORD_BITS_DEF = 8;
	localparam int TRACE_BITS_DEF = 16;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 9;
	localparam int GRID_BITS     = 9;
	localparam int CELL_BITS     = 8;
	localparam int BIAS_BITS     = 9;
	localparam int FACT_BITS     = 11;
	localparam int FRAC_BITS     = 16;
	localparam int DIR_BITS      = 3;
	localparam int NUM_SLOTS     = 4;
	localparam int CNT_BITS      = 3;
	localparam int NUM_STAGES    = 5;

	localparam logic [FACT_BITS-1:0] ONE_Q8 = 11'd256;

	localparam logic [CFG_IDX_BITS-1:0] REG_GRID_W = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_GRID_H = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_NEST_X = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_NEST_Y = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_FOOD_X = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_FOOD_Y = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_BIAS   = 3'd6;

	localparam logic [GRID_BITS-1:0] GRID_RST = 9'd64;
	localparam logic [BIAS_BITS-1:0] BIAS_RST = 9'd128;

	// neighbor slots in wheel order, same as the open mask bits
	localparam int SLOT_LEFT  = 0;
	localparam int SLOT_RIGHT = 1;
	localparam int SLOT_UP    = 2;
	localparam int SLOT_DOWN  = 3;

	typedef enum logic [DIR_BITS-1:0] {
		DIR_NONE  = 3'd0,
		DIR_UP    = 3'd1,
		DIR_RIGHT = 3'd2,
		DIR_DOWN  = 3'd3,
		DIR_LEFT  = 3'd4
	} dir_t;

	typedef struct packed {
		logic [GRID_BITS-1:0] grid_w;
		logic [GRID_BITS-1:0] grid_h;
		logic [CELL_BITS-1:0] nest_x;
		logic [CELL_BITS-1:0] nest_y;
		logic [CELL_BITS-1:0] food_x;
		logic [CELL_BITS-1:0] food_y;
		logic [BIAS_BITS-1:0] bias;
	} cfg_t;

	typedef struct packed {
		logic [NUM_SLOTS-1:0] avail;
		logic [CNT_BITS-1:0]  n_open;
		logic                 carry;
	} ctl_t;

	// bit k refers to stage k+1
	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
		logic [NUM_STAGES-1:0] full;
	} pipe_t;

	function automatic dir_t slot_dir(input logic [1:0] slot);
		dir_t d;
		case (slot)
			2'd0: d = DIR_LEFT;
			2'd1: d = DIR_RIGHT;
			2'd2: d = DIR_UP;
			2'd3: d = DIR_DOWN;
			default: d = DIR_NONE;
		endcase
		return d;
	endfunction

	function automatic dir_t opposite_dir(input dir_t d);
		dir_t o;
		case (d)
			DIR_UP:    o = DIR_DOWN;
			DIR_DOWN:  o = DIR_UP;
			DIR_LEFT:  o = DIR_RIGHT;
			DIR_RIGHT: o = DIR_LEFT;
			default:   o = DIR_NONE;
		endcase
		return o;
	endfunction

endpackage

// ===== hdl/amc_weigh.sv =====
module amc_weigh
	import amc_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int TRACE_BITS = TRACE_BITS_DEF
) (
	input  logic                  clk,
	input  pipe_t                 pipe,
	input  cfg_t                  cfg,
	input  logic [COORD_BITS-1:0] pos_x,
	input  logic [COORD_BITS-1:0] pos_y,
	input  logic [DIR_BITS-1:0]   back_dir,
	input  logic                  carrying,
	input  logic [NUM_SLOTS-1:0]  open_mask,
	input  logic [TRACE_BITS-1:0] trace [NUM_SLOTS],
	input  logic [FRAC_BITS-1:0]  rand_fraction,
	output ctl_t                  ctl_s2,
	output logic [COORD_BITS-1:0] pos_x_s2,
	output logic [COORD_BITS-1:0] pos_y_s2,
	output logic [FRAC_BITS-1:0]  rnd_s2,
	output logic [FACT_BITS+TRACE_BITS:0] w_s2 [NUM_SLOTS]
);

	localparam int EXT_BITS = ((COORD_BITS > GRID_BITS) ? COORD_BITS : GRID_BITS) + 1;
	localparam int TW_BITS  = TRACE_BITS + 1;
	localparam int WGT_BITS = FACT_BITS + TW_BITS;

	logic [EXT_BITS-1:0]  x_next, y_next;
	logic [NUM_SLOTS-1:0] avail;
	logic [CNT_BITS-1:0]  n_open;
	logic                 at_nest, at_food, rev, carry_nx;
	logic [FACT_BITS-1:0] back_f, other_f;
	logic [FACT_BITS-1:0] f [NUM_SLOTS];

	logic [FACT_BITS-1:0]  f_s1 [NUM_SLOTS];
	logic [TRACE_BITS-1:0] trc_s1 [NUM_SLOTS];
	logic [COORD_BITS-1:0] pos_x_s1, pos_y_s1;
	logic [FRAC_BITS-1:0]  rnd_s1;
	ctl_t                  ctl_s1;

	assign x_next = EXT_BITS'(pos_x) + EXT_BITS'(1);
	assign y_next = EXT_BITS'(pos_y) + EXT_BITS'(1);

	// a step off the grid or out of coordinate range is not open
	assign avail[SLOT_LEFT]  = open_mask[SLOT_LEFT] && (pos_x != '0);
	assign avail[SLOT_RIGHT] = open_mask[SLOT_RIGHT] && (pos_x != '1)
		&& (x_next < EXT_BITS'(cfg.grid_w));
	assign avail[SLOT_UP]    = open_mask[SLOT_UP] && (pos_y != '0);
	assign avail[SLOT_DOWN]  = open_mask[SLOT_DOWN] && (pos_y != '1)
		&& (y_next < EXT_BITS'(cfg.grid_h));

	assign n_open = CNT_BITS'($countones(avail));

	assign at_nest = (EXT_BITS'(pos_x) == EXT_BITS'(cfg.nest_x))
		&& (EXT_BITS'(pos_y) == EXT_BITS'(cfg.nest_y));
	assign at_food = (EXT_BITS'(pos_x) == EXT_BITS'(cfg.food_x))
		&& (EXT_BITS'(pos_y) == EXT_BITS'(cfg.food_y));

	assign rev = (back_dir == DIR_NONE) || (at_food && !carrying) || (at_nest && carrying);

	// pickup and drop apply unless exactly one move is open
	always_comb begin
		carry_nx = carrying;
		if (rev && (n_open != CNT_BITS'(1))) begin
			if (at_nest) begin
				carry_nx = 1'b0;
			end else if (at_food) begin
				carry_nx = 1'b1;
			end
		end
	end

	// factors scaled by n(n-1): back b(n-1), others 256n-b
	assign back_f  = FACT_BITS'(cfg.bias) * FACT_BITS'(n_open - CNT_BITS'(1));
	assign other_f = FACT_BITS'({n_open, 8'd0}) - FACT_BITS'(cfg.bias);

	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (!avail[i]) begin
				f[i] = '0;
			end else if (rev) begin
				f[i] = ONE_Q8;
			end else if (back_dir == slot_dir(2'(i))) begin
				f[i] = back_f;
			end else begin
				f[i] = other_f;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pipe.load[0]) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				f_s1[i]   <= f[i];
				trc_s1[i] <= trace[i];
			end
			pos_x_s1     <= pos_x;
			pos_y_s1     <= pos_y;
			rnd_s1       <= rand_fraction;
			ctl_s1.avail  <= avail;
			ctl_s1.n_open <= n_open;
			ctl_s1.carry  <= carry_nx;
		end
	end

	// weight = factor * (1.0 + trace)
	always_ff @(posedge clk) begin
		if (pipe.load[1]) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				w_s2[i] <= WGT_BITS'(f_s1[i])
					* WGT_BITS'(TW_BITS'(trc_s1[i]) + TW_BITS'(ONE_Q8));
			end
			pos_x_s2 <= pos_x_s1;
			pos_y_s2 <= pos_y_s1;
			rnd_s2   <= rnd_s1;
			ctl_s2   <= ctl_s1;
		end
	end

endmodule

// ===== hdl/amc_wheel.sv =====
`include "assert_macros.svh"

module amc_wheel
	import amc_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int TRACE_BITS = TRACE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pipe_t                 pipe,
	input  ctl_t                  ctl_s2,
	input  logic [COORD_BITS-1:0] pos_x_s2,
	input  logic [COORD_BITS-1:0] pos_y_s2,
	input  logic [FRAC_BITS-1:0]  rnd_s2,
	input  logic [FACT_BITS+TRACE_BITS:0] w_s2 [NUM_SLOTS],
	output logic [COORD_BITS-1:0] new_x_s5,
	output logic [COORD_BITS-1:0] new_y_s5,
	output logic [DIR_BITS-1:0]   new_back_dir_s5,
	output logic                  new_carrying_s5,
	output logic [DIR_BITS-1:0]   chosen_dir_s5,
	output logic                  stuck_s5
);

	localparam int WGT_BITS  = FACT_BITS + TRACE_BITS + 1;
	localparam int SUM_BITS  = WGT_BITS + 2;
	localparam int PROD_BITS = SUM_BITS + FRAC_BITS;

	logic [SUM_BITS-1:0]   p_s3 [NUM_SLOTS];
	logic [FRAC_BITS-1:0]  rnd_s3;
	logic [COORD_BITS-1:0] pos_x_s3, pos_y_s3;
	ctl_t                  ctl_s3;

	logic [PROD_BITS-1:0]  prod;
	logic [SUM_BITS-1:0]   r_s4;
	logic [SUM_BITS-1:0]   p_s4 [NUM_SLOTS-1];
	logic [COORD_BITS-1:0] pos_x_s4, pos_y_s4;
	ctl_t                  ctl_s4;

	logic [NUM_SLOTS-1:0]  last_oh, sel_oh;
	logic                  found;
	dir_t                  chosen;
	logic [COORD_BITS-1:0] nx, ny;

	// running sums, unavailable slots weigh zero
	always_ff @(posedge clk) begin
		if (pipe.load[2]) begin
			p_s3[0] <= SUM_BITS'(w_s2[0]);
			p_s3[1] <= SUM_BITS'(w_s2[0]) + SUM_BITS'(w_s2[1]);
			p_s3[2] <= SUM_BITS'(w_s2[0]) + SUM_BITS'(w_s2[1]) + SUM_BITS'(w_s2[2]);
			p_s3[3] <= SUM_BITS'(w_s2[0]) + SUM_BITS'(w_s2[1])
				+ SUM_BITS'(w_s2[2]) + SUM_BITS'(w_s2[3]);
			rnd_s3   <= rnd_s2;
			pos_x_s3 <= pos_x_s2;
			pos_y_s3 <= pos_y_s2;
			ctl_s3   <= ctl_s2;
		end
	end

	// draw point on the wheel: total * fraction
	assign prod = PROD_BITS'(p_s3[NUM_SLOTS-1]) * PROD_BITS'(rnd_s3);

	always_ff @(posedge clk) begin
		if (pipe.load[3]) begin
			r_s4 <= prod[PROD_BITS-1:FRAC_BITS];
			for (int i = 0; i < NUM_SLOTS - 1; i++) begin
				p_s4[i] <= p_s3[i];
			end
			pos_x_s4 <= pos_x_s3;
			pos_y_s4 <= pos_y_s3;
			ctl_s4   <= ctl_s3;
		end
	end

	// last open slot also serves a single move and a rounding miss
	always_comb begin
		last_oh = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (ctl_s4.avail[i]) begin
				last_oh = NUM_SLOTS'(1) << i;
			end
		end
	end

	always_comb begin
		sel_oh = '0;
		found  = 1'b0;
		if (ctl_s4.n_open >= CNT_BITS'(2)) begin
			for (int i = 0; i < NUM_SLOTS - 1; i++) begin
				if (!found && (r_s4 < p_s4[i])) begin
					sel_oh[i] = 1'b1;
					found     = 1'b1;
				end
			end
		end
		if (!found) begin
			sel_oh = last_oh;
		end
	end

	always_comb begin
		chosen = DIR_NONE;
		nx     = pos_x_s4;
		ny     = pos_y_s4;
		if (sel_oh[SLOT_LEFT]) begin
			chosen = DIR_LEFT;
			nx     = pos_x_s4 - COORD_BITS'(1);
		end else if (sel_oh[SLOT_RIGHT]) begin
			chosen = DIR_RIGHT;
			nx     = pos_x_s4 + COORD_BITS'(1);
		end else if (sel_oh[SLOT_UP]) begin
			chosen = DIR_UP;
			ny     = pos_y_s4 - COORD_BITS'(1);
		end else if (sel_oh[SLOT_DOWN]) begin
			chosen = DIR_DOWN;
			ny     = pos_y_s4 + COORD_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pipe.load[4]) begin
			new_x_s5        <= nx;
			new_y_s5        <= ny;
			chosen_dir_s5   <= chosen;
			new_back_dir_s5 <= opposite_dir(chosen);
			new_carrying_s5 <= ctl_s4.carry;
			stuck_s5        <= (ctl_s4.n_open == '0);
		end
	end

	`ASSERT_IMPL(a_sel_open, pipe.load[4] && pipe.full[3], $onehot0(sel_oh) && ((sel_oh & ~ctl_s4.avail) == '0), "move chosen from a closed neighbor")
	`ASSERT_IMPL(a_stuck_none, pipe.full[4] && stuck_s5, (chosen_dir_s5 == DIR_NONE) && (new_back_dir_s5 == DIR_NONE), "stuck item carries a direction")

endmodule

// ===== hdl/ant_pheromone_move_choice_core.sv =====
// channel   | dir | handshake                  | payload
// s_        | in  | s_tvalid / s_tready        | s_tdata: one ant with neighbor traces
// m_        | out | m_tvalid / m_tready        | m_tdata: move result
// cfg_      | in  | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// five register stages: factors, weights, running sums, draw, selection
// one item per cycle sustained while m_tready stays high; a stalled output holds the flow
// each stage holds its item while the next one is full and stalled, bubbles fill in
// arst_n clears valid bits and loads register reset values; cfg_ready is always high
`include "assert_macros.svh"

module ant_pheromone_move_choice_core
	import amc_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int TRACE_BITS = TRACE_BITS_DEF,
	localparam int X_LO     = 0,
	localparam int Y_LO     = COORD_BITS,
	localparam int BD_LO    = 2 * COORD_BITS,
	localparam int CR_LO    = BD_LO + DIR_BITS,
	localparam int OM_LO    = CR_LO + 1,
	localparam int TR_LO    = OM_LO + NUM_SLOTS,
	localparam int RF_LO    = TR_LO + NUM_SLOTS * TRACE_BITS,
	localparam int IN_RAW   = RF_LO + FRAC_BITS,
	localparam int IN_BITS  = ((IN_RAW + 7) / 8) * 8,
	localparam int OUT_RAW  = 2 * COORD_BITS + 2 * DIR_BITS + 2,
	localparam int OUT_BITS = ((OUT_RAW + 7) / 8) * 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// pos_x, pos_y, back_dir, carrying, open_mask, trace_left, trace_right,
	// trace_up, trace_down, rand_fraction
	input  logic [IN_BITS-1:0]       s_tdata,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// new_x, new_y, new_back_dir, new_carrying, chosen_dir, stuck
	output logic [OUT_BITS-1:0]      m_tdata,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	cfg_t                  cfg_q;
	logic [NUM_STAGES-1:0] pipe_valid_q;
	logic [NUM_STAGES-1:0] rdy;
	pipe_t                 pipe;

	logic [TRACE_BITS-1:0] trace [NUM_SLOTS];

	ctl_t                  ctl_s2;
	logic [COORD_BITS-1:0] pos_x_s2, pos_y_s2;
	logic [FRAC_BITS-1:0]  rnd_s2;
	logic [FACT_BITS+TRACE_BITS:0] w_s2 [NUM_SLOTS];

	logic [COORD_BITS-1:0] new_x_s5, new_y_s5;
	logic [DIR_BITS-1:0]   new_back_dir_s5, chosen_dir_s5;
	logic                  new_carrying_s5, stuck_s5;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_w <= GRID_RST;
			cfg_q.grid_h <= GRID_RST;
			cfg_q.nest_x <= '0;
			cfg_q.nest_y <= '0;
			cfg_q.food_x <= '0;
			cfg_q.food_y <= '0;
			cfg_q.bias   <= BIAS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GRID_W: cfg_q.grid_w <= cfg_data;
				REG_GRID_H: cfg_q.grid_h <= cfg_data;
				REG_NEST_X: cfg_q.nest_x <= cfg_data[CELL_BITS-1:0];
				REG_NEST_Y: cfg_q.nest_y <= cfg_data[CELL_BITS-1:0];
				REG_FOOD_X: cfg_q.food_x <= cfg_data[CELL_BITS-1:0];
				REG_FOOD_Y: cfg_q.food_y <= cfg_data[CELL_BITS-1:0];
				REG_BIAS:   cfg_q.bias   <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage takes a new item when it is empty or its item moves on
	always_comb begin
		rdy[NUM_STAGES-1] = !pipe_valid_q[NUM_STAGES-1] || m_tready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			rdy[k] = !pipe_valid_q[k] || rdy[k+1];
		end
	end

	always_comb begin
		pipe.full    = pipe_valid_q;
		pipe.load[0] = rdy[0] && s_tvalid;
		for (int k = 1; k < NUM_STAGES; k++) begin
			pipe.load[k] = rdy[k] && pipe_valid_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_valid_q <= '0;
		end else begin
			if (rdy[0]) begin
				pipe_valid_q[0] <= s_tvalid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (rdy[k]) begin
					pipe_valid_q[k] <= pipe_valid_q[k-1];
				end
			end
		end
	end

	assign s_tready = rdy[0];
	assign m_tvalid = pipe_valid_q[NUM_STAGES-1];

	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			trace[i] = s_tdata[TR_LO + i * TRACE_BITS +: TRACE_BITS];
		end
	end

	amc_weigh #(
		.COORD_BITS (COORD_BITS),
		.TRACE_BITS (TRACE_BITS)
	) u_weigh (
		.clk           (clk),
		.pipe          (pipe),
		.cfg           (cfg_q),
		.pos_x         (s_tdata[X_LO +: COORD_BITS]),
		.pos_y         (s_tdata[Y_LO +: COORD_BITS]),
		.back_dir      (s_tdata[BD_LO +: DIR_BITS]),
		.carrying      (s_tdata[CR_LO]),
		.open_mask     (s_tdata[OM_LO +: NUM_SLOTS]),
		.trace         (trace),
		.rand_fraction (s_tdata[RF_LO +: FRAC_BITS]),
		.ctl_s2        (ctl_s2),
		.pos_x_s2      (pos_x_s2),
		.pos_y_s2      (pos_y_s2),
		.rnd_s2        (rnd_s2),
		.w_s2          (w_s2)
	);

	amc_wheel #(
		.COORD_BITS (COORD_BITS),
		.TRACE_BITS (TRACE_BITS)
	) u_wheel (
		.clk             (clk),
		.arst_n          (arst_n),
		.pipe            (pipe),
		.ctl_s2          (ctl_s2),
		.pos_x_s2        (pos_x_s2),
		.pos_y_s2        (pos_y_s2),
		.rnd_s2          (rnd_s2),
		.w_s2            (w_s2),
		.new_x_s5        (new_x_s5),
		.new_y_s5        (new_y_s5),
		.new_back_dir_s5 (new_back_dir_s5),
		.new_carrying_s5 (new_carrying_s5),
		.chosen_dir_s5   (chosen_dir_s5),
		.stuck_s5        (stuck_s5)
	);

	assign m_tdata = OUT_BITS'({stuck_s5, chosen_dir_s5, new_carrying_s5,
		new_back_dir_s5, new_y_s5, new_x_s5});

	`ASSERT_IMPL(a_ready_full, !s_tready, (&pipe_valid_q) && !m_tready, "input stalled with room in the pipeline")
	`ASSERT_NEXT(a_in_fill, s_tvalid && s_tready, pipe_valid_q[0], "accepted item not in first stage")
	`ASSERT_NEXT(a_s4_hold, pipe_valid_q[3] && !rdy[4], pipe_valid_q[3] && pipe_valid_q[4], "stalled item dropped before output")

endmodule

// ===== tb/tb_ant_pheromone_move_choice_core.sv =====
module tb_ant_pheromone_move_choice_core;
	import amc_pkg::*;

	// field order from the msb down, so that pos_x lands in bit 0
	typedef struct packed {
		logic [FRAC_BITS-1:0] rand_fraction;
		logic [15:0]          trace_down;
		logic [15:0]          trace_up;
		logic [15:0]          trace_right;
		logic [15:0]          trace_left;
		logic [NUM_SLOTS-1:0] open_mask;
		logic                 carrying;
		logic [DIR_BITS-1:0]  back_dir;
		logic [CELL_BITS-1:0] pos_y;
		logic [CELL_BITS-1:0] pos_x;
	} ant_t;

	typedef struct packed {
		logic                 stuck;
		logic [DIR_BITS-1:0]  chosen_dir;
		logic                 new_carrying;
		logic [DIR_BITS-1:0]  new_back_dir;
		logic [CELL_BITS-1:0] new_y;
		logic [CELL_BITS-1:0] new_x;
	} move_t;

	localparam int IDLE_LIMIT = 2000;

	class move_scoreboard;
		logic [GRID_BITS-1:0] grid_w;
		logic [GRID_BITS-1:0] grid_h;
		logic [CELL_BITS-1:0] nest_x;
		logic [CELL_BITS-1:0] nest_y;
		logic [CELL_BITS-1:0] food_x;
		logic [CELL_BITS-1:0] food_y;
		logic [BIAS_BITS-1:0] bias;
		move_t pending_moves[$];
		int errors;

		function new();
			grid_w = GRID_RST;
			grid_h = GRID_RST;
			nest_x = '0;
			nest_y = '0;
			food_x = '0;
			food_y = '0;
			bias = BIAS_RST;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
			case (idx)
				REG_GRID_W: grid_w = val;
				REG_GRID_H: grid_h = val;
				REG_NEST_X: nest_x = val[CELL_BITS-1:0];
				REG_NEST_Y: nest_y = val[CELL_BITS-1:0];
				REG_FOOD_X: food_x = val[CELL_BITS-1:0];
				REG_FOOD_Y: food_y = val[CELL_BITS-1:0];
				REG_BIAS:   bias = val;
				default: ;
			endcase
		endfunction

		function move_t choose_move(ant_t a);
			dir_t dirs[4];
			longint unsigned trc[4];
			longint unsigned wt[4];
			longint unsigned total, r, f;
			int n, i;
			bit carry, at_nest, at_food, rev, done;
			dir_t pick, back;
			move_t m;
			n = 0;
			pick = DIR_NONE;
			carry = a.carrying;
			at_nest = (a.pos_x == nest_x) && (a.pos_y == nest_y);
			at_food = (a.pos_x == food_x) && (a.pos_y == food_y);
			if (a.pos_x != 0 && a.open_mask[SLOT_LEFT]) begin
				dirs[n] = DIR_LEFT;
				trc[n] = 64'(a.trace_left);
				n++;
			end
			if (int'(a.pos_x) + 1 < int'(grid_w) && a.pos_x != 8'hFF
					&& a.open_mask[SLOT_RIGHT]) begin
				dirs[n] = DIR_RIGHT;
				trc[n] = 64'(a.trace_right);
				n++;
			end
			if (a.pos_y != 0 && a.open_mask[SLOT_UP]) begin
				dirs[n] = DIR_UP;
				trc[n] = 64'(a.trace_up);
				n++;
			end
			if (int'(a.pos_y) + 1 < int'(grid_h) && a.pos_y != 8'hFF
					&& a.open_mask[SLOT_DOWN]) begin
				dirs[n] = DIR_DOWN;
				trc[n] = 64'(a.trace_down);
				n++;
			end
			if (n == 1) begin
				pick = dirs[0];
			end else begin
				rev = (a.back_dir == DIR_NONE) || (at_food && !carry) || (at_nest && carry);
				if (rev) begin
					if (at_nest)
						carry = 1'b0;
					else if (at_food)
						carry = 1'b1;
				end
				if (n >= 2) begin
					total = 0;
					for (i = 0; i < n; i++) begin
						if (rev)
							f = 256;
						else if (dirs[i] == a.back_dir)
							f = longint'(bias) * (n - 1);
						else
							f = longint'(256 * n) - longint'(bias);
						wt[i] = f * (256 + trc[i]);
						total += wt[i];
					end
					r = (total * 64'(a.rand_fraction)) >> 16;
					// a wheel that overshoots falls back to the last move
					pick = dirs[n-1];
					done = 0;
					for (i = 0; i < n; i++) begin
						if (!done) begin
							if (r < wt[i]) begin
								pick = dirs[i];
								done = 1;
							end else begin
								r -= wt[i];
							end
						end
					end
				end
			end
			m.new_x = a.pos_x;
			m.new_y = a.pos_y;
			case (pick)
				DIR_UP:    m.new_y = a.pos_y - 8'd1;
				DIR_DOWN:  m.new_y = a.pos_y + 8'd1;
				DIR_LEFT:  m.new_x = a.pos_x - 8'd1;
				DIR_RIGHT: m.new_x = a.pos_x + 8'd1;
				default: ;
			endcase
			case (pick)
				DIR_UP:    back = DIR_DOWN;
				DIR_DOWN:  back = DIR_UP;
				DIR_LEFT:  back = DIR_RIGHT;
				DIR_RIGHT: back = DIR_LEFT;
				default:   back = DIR_NONE;
			endcase
			m.new_back_dir = back;
			m.new_carrying = carry;
			m.chosen_dir = pick;
			m.stuck = (n == 0);
			return m;
		endfunction

		function void note_ant(ant_t a);
			pending_moves = {pending_moves, choose_move(a)};
		endfunction

		function void check_move(move_t got);
			move_t want;
			if (pending_moves.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("move result with none pending: %h", got);
				return;
			end
			want = pending_moves.pop_front();
			if (got.new_x !== want.new_x || got.new_y !== want.new_y ||
					got.new_back_dir !== want.new_back_dir ||
					got.new_carrying !== want.new_carrying ||
					got.chosen_dir !== want.chosen_dir || got.stuck !== want.stuck) begin
				errors++;
				if (errors <= 10) begin
					$display("move mismatch: exp x=%0d y=%0d back=%0d carry=%0d dir=%0d stuck=%0d",
						want.new_x, want.new_y, want.new_back_dir, want.new_carrying,
						want.chosen_dir, want.stuck);
					$display("               got x=%0d y=%0d back=%0d carry=%0d dir=%0d stuck=%0d",
						got.new_x, got.new_y, got.new_back_dir, got.new_carrying,
						got.chosen_dir, got.stuck);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [$bits(ant_t)-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [$bits(move_t)-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	move_scoreboard sb;
	bit calm = 0;
	int idle_cycles = 0;

	ant_pheromone_move_choice_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// downstream stalls in bursts, none once the run goes calm
	initial begin
		@(posedge clk iff arst_n);
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			if (!calm) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				sb.note_ant(s_tdata);
			if (m_tvalid && m_tready)
				sb.check_move(m_tdata);
			if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("tb_ant_pheromone_move_choice_core: errors");
					$finish;
				end
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int val);
		cfg_index <= idx;
		cfg_data <= CFG_DATA_BITS'(val);
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_world(int gw, int gh, int nx, int ny, int fx, int fy, int bias);
		write_reg(REG_GRID_W, gw);
		write_reg(REG_GRID_H, gh);
		write_reg(REG_NEST_X, nx);
		write_reg(REG_NEST_Y, ny);
		write_reg(REG_FOOD_X, fx);
		write_reg(REG_FOOD_Y, fy);
		write_reg(REG_BIAS, bias);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_ant(ant_t a, bit may_idle);
		if (may_idle && !calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tdata <= a;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// lets the pipeline empty out before registers change
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_moves.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic ant_t mk_ant(int x, int y, logic [DIR_BITS-1:0] bd, bit carry,
			logic [NUM_SLOTS-1:0] mask, int tl, int tr, int tu, int td, int frac);
		ant_t a;
		a.pos_x = CELL_BITS'(x);
		a.pos_y = CELL_BITS'(y);
		a.back_dir = bd;
		a.carrying = carry;
		a.open_mask = mask;
		a.trace_left = 16'(tl);
		a.trace_right = 16'(tr);
		a.trace_up = 16'(tu);
		a.trace_down = 16'(td);
		a.rand_fraction = FRAC_BITS'(frac);
		return a;
	endfunction

	function automatic logic [15:0] rand_trace();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 1023));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic ant_t random_ant();
		ant_t a;
		int lim_x, lim_y;
		lim_x = (sb.grid_w == 0 || sb.grid_w > 256) ? 255 : int'(sb.grid_w) - 1;
		lim_y = (sb.grid_h == 0 || sb.grid_h > 256) ? 255 : int'(sb.grid_h) - 1;
		case ($urandom_range(0, 9))
			0: begin
				a.pos_x = CELL_BITS'($urandom_range(0, 255));
				a.pos_y = CELL_BITS'($urandom_range(0, 255));
			end
			1: begin
				a.pos_x = sb.nest_x;
				a.pos_y = sb.nest_y;
			end
			2: begin
				a.pos_x = sb.food_x;
				a.pos_y = sb.food_y;
			end
			3: begin
				a.pos_x = CELL_BITS'($urandom_range(0, 1) ? lim_x : 0);
				a.pos_y = CELL_BITS'($urandom_range(0, 1) ? lim_y : 0);
			end
			default: begin
				a.pos_x = CELL_BITS'($urandom_range(0, lim_x));
				a.pos_y = CELL_BITS'($urandom_range(0, lim_y));
			end
		endcase
		// codes above four are not real directions but must still be handled
		if ($urandom_range(0, 15) == 0)
			a.back_dir = DIR_BITS'($urandom_range(5, 7));
		else
			a.back_dir = DIR_BITS'($urandom_range(0, 4));
		a.carrying = 1'($urandom_range(0, 1));
		a.open_mask = $urandom_range(0, 1) ? 4'hF : 4'($urandom_range(0, 15));
		a.trace_left = rand_trace();
		a.trace_right = rand_trace();
		a.trace_up = rand_trace();
		a.trace_down = rand_trace();
		case ($urandom_range(0, 7))
			0: a.rand_fraction = 16'h0000;
			1: a.rand_fraction = 16'hFFFF;
			default: a.rand_fraction = FRAC_BITS'($urandom);
		endcase
		return a;
	endfunction

	task automatic run_ants(int count);
		repeat (count) send_ant(random_ant(), 1'b1);
		drain();
	endtask

	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register reset values, nest and food share the corner
		run_ants(60);

		set_world(16, 16, 3, 3, 12, 10, 128);
		send_ant(mk_ant(0, 0, DIR_NONE, 0, 4'hF, 0, 0, 0, 0, 0), 1'b0);
		send_ant(mk_ant(15, 15, DIR_RIGHT, 1, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF), 1'b0);
		// nothing open, away from nest and at the nest
		send_ant(mk_ant(5, 5, DIR_NONE, 1, 4'h0, 5, 6, 7, 8, 100), 1'b0);
		send_ant(mk_ant(3, 3, DIR_UP, 1, 4'h0, 5, 6, 7, 8, 100), 1'b0);
		// one open move keeps the food flag even at the nest
		send_ant(mk_ant(3, 3, DIR_LEFT, 1, 4'b0001, 9, 9, 9, 9, 16'hFFFF), 1'b0);
		send_ant(mk_ant(12, 10, DIR_DOWN, 0, 4'hF, 100, 200, 300, 400, 16'h8000), 1'b0);
		send_ant(mk_ant(3, 3, DIR_UP, 1, 4'hF, 400, 300, 200, 100, 16'hC000), 1'b0);
		send_ant(mk_ant(12, 10, DIR_NONE, 1, 4'hF, 0, 0, 0, 0, 16'h7FFF), 1'b0);
		send_ant(mk_ant(7, 7, 3'd5, 0, 4'hF, 1, 2, 3, 4, 16'h2000), 1'b0);
		send_ant(mk_ant(7, 7, 3'd6, 1, 4'hF, 16'hFFFF, 0, 16'hFFFF, 0, 16'hA000), 1'b0);
		send_ant(mk_ant(7, 7, 3'd7, 0, 4'hF, 0, 16'hFFFF, 0, 16'hFFFF, 16'hE000), 1'b0);
		// coming from the left with the left side closed
		send_ant(mk_ant(7, 7, DIR_LEFT, 0, 4'b1110, 50, 60, 70, 80, 16'h5555), 1'b0);
		send_ant(mk_ant(7, 7, DIR_UP, 0, 4'hF, 0, 0, 0, 0, 16'h4000), 1'b0);
		send_ant(mk_ant(7, 7, DIR_RIGHT, 1, 4'hF, 0, 0, 0, 0, 16'h8000), 1'b0);
		send_ant(mk_ant(7, 7, DIR_DOWN, 0, 4'hF, 0, 0, 0, 0, 16'hC000), 1'b0);
		send_ant(mk_ant(7, 7, DIR_LEFT, 1, 4'hF, 0, 0, 0, 0, 16'hFFFF), 1'b0);
		// far outside the grid only left and up remain
		send_ant(mk_ant(255, 255, DIR_NONE, 0, 4'hF, 1000, 1000, 1000, 1000, 16'h9000), 1'b0);
		send_ant(mk_ant(255, 0, DIR_DOWN, 1, 4'hF, 0, 0, 0, 0, 16'h1000), 1'b0);
		send_ant(mk_ant(0, 15, DIR_UP, 0, 4'b1010, 0, 0, 0, 0, 16'h3000), 1'b0);
		send_ant(mk_ant(7, 7, DIR_RIGHT, 0, 4'b0011, 0, 0, 0, 16'hFFFF, 16'hFFFF), 1'b0);
		run_ants(200);

		set_world(256, 256, 0, 0, 255, 255, 0);
		run_ants(200);
		set_world(1, 1, 0, 0, 0, 0, 256);
		run_ants(100);
		set_world(2, 3, 1, 2, 0, 0, 256);
		run_ants(150);
		// zero-width grid: no move to the right is ever open
		set_world(0, 5, 4, 1, 2, 3, 64);
		run_ants(100);
		set_world(64, 64, $urandom_range(0, 63), $urandom_range(0, 63),
			$urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 256));
		run_ants(250);

		calm = 1;
		set_world($urandom_range(1, 256), $urandom_range(1, 256), $urandom_range(0, 31),
			$urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
			$urandom_range(0, 256));
		run_ants(300);

		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending_moves.size() == 0) begin
			$display("tb_ant_pheromone_move_choice_core: clean");
		end else begin
			$display("tb_ant_pheromone_move_choice_core: errors");
		end
		$finish;
	end

endmodule
